[sv/assert_macros.svh]
// Assertion macros for the checker file of the convolution block.
// Needs nothing else; include it inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define C3BR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define C3BR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define C3BR_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/c3br_pkg.sv]
// Package of the 3x3 convolution block: operation and register codes,
// accumulator type, controller states and the cell control bundle. No dependencies.
`default_nettype none

package c3br_pkg;

   localparam int ACC_W  = 48;
   localparam int FRAC_W = 12;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_IN_CHANS   = 2'd2;
   localparam logic [1:0] CSR_OUT_CHANS  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN,
      ST_UNLOAD
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       shift;
      logic       wt_we;
      logic       bias_we;
      logic [5:0] filter;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[sv/c3br_ifs.sv]
// Handshake interfaces of the convolution block: request, response and
// register write channels. No dependencies.
`default_nettype none

interface c3br_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [4:0]         filter_index;
   logic [1:0]         tap_row;
   logic [1:0]         tap_col;
   logic [4:0]         channel_index;
   logic signed [15:0] value;
   modport source (output valid, op, filter_index, tap_row, tap_col, channel_index, value,
                   input ready);
   modport sink   (input valid, op, filter_index, tap_row, tap_col, channel_index, value,
                   output ready);
endinterface

interface c3br_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  out_row;
   logic [4:0]  out_col;
   logic [4:0]  out_channel;
   logic [14:0] activation;
   logic        last;
   modport source (output valid, out_row, out_col, out_channel, activation, last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_channel, activation, last,
                   output ready);
endinterface

interface c3br_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [5:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/c3br_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module c3br_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 288
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

[sv/c3br_cell.sv]
// One filter cell: own weight RAM, bias, multiplier and accumulator; passes
// samples on to the next cell. Depends on c3br_pkg and c3br_ram.
`default_nettype none

module c3br_cell #(
   parameter int CELL_ID   = 0,
   parameter int TAP_DEPTH = 288
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire c3br_pkg::cell_ctrl_type      ctrl,
   input  wire logic [$clog2(TAP_DEPTH)-1:0] wt_addr,
   input  wire logic signed [15:0]           wr_value,
   input  wire logic                         in_vld,
   input  wire logic signed [15:0]           in_x,
   input  wire logic [$clog2(TAP_DEPTH)-1:0] in_tap,
   output logic                              out_vld,
   output logic signed [15:0]                out_x,
   output logic [$clog2(TAP_DEPTH)-1:0]      out_tap,
   input  wire c3br_pkg::acc_type            nbr_acc,
   output c3br_pkg::acc_type                 acc
);
   import c3br_pkg::*;

   localparam int TW = $clog2(TAP_DEPTH);
   localparam logic [5:0] MY_ID = 6'(CELL_ID);

   logic                 a_vld_ff, b_vld_ff, p_vld_ff;
   logic signed [15:0]   a_x_ff, b_x_ff;
   logic [TW-1:0]        a_tap_ff;
   logic signed [31:0]   p_ff;
   logic signed [15:0]   bias_ff;
   logic [15:0]          wt_rd;
   acc_type              acc_ff, acc_in;
   logic                 wt_we;

   assign wt_we = ctrl.wt_we && (ctrl.filter == MY_ID);

   c3br_ram #(.WIDTH(16), .DEPTH(TAP_DEPTH)) u_wt (
      .clock (clock),
      .we    (wt_we),
      .waddr (wt_addr),
      .wdata (wr_value),
      .raddr (a_tap_ff),
      .rdata (wt_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
         p_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff   <= in_x;
      a_tap_ff <= in_tap;
      b_x_ff   <= a_x_ff;
      p_ff     <= b_x_ff * $signed(wt_rd);
      if (ctrl.bias_we && (ctrl.filter == MY_ID)) begin
         bias_ff <= wr_value;
      end
      acc_ff <= acc_in;
   end

   // seed with the bias, unload toward cell 0, else accumulate
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = acc_type'(bias_ff) <<< FRAC_W;
      end else if (ctrl.shift) begin
         acc_in = nbr_acc;
      end else if (p_vld_ff) begin
         acc_in = acc_ff + acc_type'(p_ff);
      end
   end

   assign out_vld = a_vld_ff;
   assign out_x   = a_x_ff;
   assign out_tap = a_tap_ff;
   assign acc     = acc_ff;
endmodule

`default_nettype wire

[sv/conv3x3_bias_relu.sv]
// Top level of the 3x3 valid convolution with bias and ReLU: controller,
// line RAM and the row of filter cells. Depends on c3br_pkg, c3br_ifs, c3br_ram, c3br_cell.
//
//   port      dir   role
//   req_bus   sink  weight, bias and sample words
//   rsp_bus   src   activation words, one per filter in use
//   csr_bus   sink  register writes (width, height, in/out channels)
//
// A weight, bias or non-final sample word is taken while idle. A sample that
// completes an output pixel starts a feed of 9*C taps (C = input channels in use,
// one line-RAM read per tap), then a drain whose length the cell chain sets, then
// an unload of K activations. Reset clears counters, registers and handshakes;
// RAM contents stay undefined. A stalled response holds the unload; request
// ready is low until it completes.
`default_nettype none

module conv3x3_bias_relu #(
   parameter int MAX_WIDTH    = 32,
   parameter int IN_CHANNELS  = 32,
   parameter int OUT_CHANNELS = 32
) (
   input wire logic    clock,
   input wire logic    reset,
   c3br_req_if.sink    req_bus,
   c3br_rsp_if.source  rsp_bus,
   c3br_csr_if.sink    csr_bus
);
   import c3br_pkg::*;

   localparam int LINE_DEPTH = 3 * MAX_WIDTH * IN_CHANNELS;
   localparam int LA         = $clog2(LINE_DEPTH);
   localparam int TAP_DEPTH  = 9 * IN_CHANNELS;
   localparam int TW         = $clog2(TAP_DEPTH);
   localparam int MAX_OUT    = (OUT_CHANNELS < 32) ? OUT_CHANNELS : 32;
   localparam int DRAIN_CYC  = OUT_CHANNELS + 6;
   localparam int DW         = $clog2(DRAIN_CYC + 1);
   localparam int QW         = ACC_W - FRAC_W;

   // ---------------- register file ----------------
   logic [5:0] width_ff, height_ff, inch_ff, outch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 6'd30;
         height_ff <= 6'd30;
         inch_ff   <= 6'd1;
         outch_ff  <= 6'd32;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MAP_WIDTH:  width_ff  <= csr_bus.data;
            CSR_MAP_HEIGHT: height_ff <= csr_bus.data;
            CSR_IN_CHANS:   inch_ff   <= csr_bus.data;
            CSR_OUT_CHANS:  outch_ff  <= csr_bus.data;
            default:        width_ff  <= width_ff;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // clamp the registers into their working ranges
   logic [5:0] eff_w, eff_h, eff_c, eff_k;
   assign eff_w = (width_ff < 6'd3) ? 6'd3 :
                  ((int'(width_ff) > MAX_WIDTH) ? 6'(MAX_WIDTH) : width_ff);
   assign eff_h = (height_ff < 6'd3) ? 6'd3 : ((height_ff > 6'd32) ? 6'd32 : height_ff);
   assign eff_c = (inch_ff == 6'd0) ? 6'd1 :
                  ((int'(inch_ff) > IN_CHANNELS) ? 6'(IN_CHANNELS) : inch_ff);
   assign eff_k = (outch_ff == 6'd0) ? 6'd1 :
                  ((int'(outch_ff) > MAX_OUT) ? 6'(MAX_OUT) : outch_ff);

   // ---------------- state machine ----------------
   state_type state_ff, state_in;
   logic      req_fire, is_sample, pix_fire, feed_done, unload_en, fi_last;
   logic      rsp_vld_ff;
   logic [DW-1:0] dr_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire && is_sample && pix_fire) state_in = ST_FEED;
         ST_FEED:   if (feed_done) state_in = ST_DRAIN;
         ST_DRAIN:  if (dr_ff == '0) state_in = ST_UNLOAD;
         ST_UNLOAD: if (unload_en && fi_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   logic feed_en;
   always_comb begin
      req_bus.ready = 1'b0;
      feed_en       = 1'b0;
      unload_en     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_FEED:   feed_en = 1'b1;
         ST_UNLOAD: unload_en = !rsp_vld_ff || rsp_bus.ready;
         default:   feed_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign is_sample = (req_bus.op == OP_SAMPLE);

   // ---------------- raster counters ----------------
   logic [4:0] row_ff;
   logic [5:0] col_ff, chan_ff;
   logic [1:0] slot_ff;
   logic       wrap;
   logic [4:0] cur_row;
   logic [5:0] cur_col, cur_ch;
   logic [1:0] cur_slot;
   logic       ch_end, col_end, row_end;

   // a count past a shrunken limit starts a new frame
   assign wrap = ({1'b0, row_ff} >= eff_h) || (col_ff >= eff_w) || (chan_ff >= eff_c);
   assign cur_row  = wrap ? 5'd0 : row_ff;
   assign cur_col  = wrap ? 6'd0 : col_ff;
   assign cur_ch   = wrap ? 6'd0 : chan_ff;
   assign cur_slot = wrap ? 2'd0 : slot_ff;

   assign ch_end  = ({1'b0, cur_ch} + 7'd1) == {1'b0, eff_c};
   assign col_end = ({1'b0, cur_col} + 7'd1) >= {1'b0, eff_w};
   assign row_end = ({1'b0, cur_row} + 6'd1) >= eff_h;
   assign pix_fire = ch_end && (cur_row >= 5'd2) && (cur_col >= 6'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         chan_ff <= '0;
         slot_ff <= '0;
      end else if (req_fire && is_sample) begin
         row_ff  <= cur_row;
         col_ff  <= cur_col;
         slot_ff <= cur_slot;
         chan_ff <= cur_ch + 6'd1;
         if (ch_end) begin
            chan_ff <= '0;
            col_ff  <= cur_col + 6'd1;
            if (col_end) begin
               col_ff  <= '0;
               row_ff  <= cur_row + 5'd1;
               slot_ff <= (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
               if (row_end) begin
                  row_ff  <= '0;
                  slot_ff <= '0;
               end
            end
         end
      end
   end

   // latch the window origin for the feed
   logic [4:0] orow_ff, ocol_ff;
   logic [5:0] colbase_ff;
   logic [1:0] base_slot_ff;

   always_ff @(posedge clock) begin
      if (req_fire && is_sample && pix_fire) begin
         orow_ff      <= cur_row - 5'd2;
         ocol_ff      <= 5'(cur_col - 6'd2);
         colbase_ff   <= cur_col - 6'd2;
         base_slot_ff <= (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
      end
   end

   // ---------------- feed sequencer: one tap per cycle ----------------
   logic [1:0] ki_ff, li_ff;
   logic [5:0] m_ff;
   logic       m_last;
   logic [2:0] slot_sum;
   logic [1:0] rd_slot;
   logic [5:0] rd_col;
   logic [LA-1:0] line_raddr, line_waddr;
   logic [TW-1:0] feed_tap;
   logic          feed_vld_ff;
   logic [TW-1:0] feed_tap_ff;

   assign m_last    = ({1'b0, m_ff} + 7'd1) == {1'b0, eff_c};
   assign feed_done = m_last && (li_ff == 2'd2) && (ki_ff == 2'd2);
   assign slot_sum  = {1'b0, base_slot_ff} + {1'b0, ki_ff};
   assign rd_slot   = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];
   assign rd_col    = colbase_ff + {4'd0, li_ff};
   assign line_raddr = LA'((int'(rd_slot) * MAX_WIDTH + int'(rd_col)) * IN_CHANNELS
                           + int'(m_ff));
   assign line_waddr = LA'((int'(cur_slot) * MAX_WIDTH + int'(cur_col)) * IN_CHANNELS
                           + int'(cur_ch));
   assign feed_tap  = TW'((int'(ki_ff) * 3 + int'(li_ff)) * IN_CHANNELS + int'(m_ff));

   always_ff @(posedge clock) begin
      if (reset || !feed_en) begin
         ki_ff <= '0;
         li_ff <= '0;
         m_ff  <= '0;
      end else begin
         m_ff <= m_ff + 6'd1;
         if (m_last) begin
            m_ff  <= '0;
            li_ff <= li_ff + 2'd1;
            if (li_ff == 2'd2) begin
               li_ff <= '0;
               ki_ff <= ki_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) feed_vld_ff <= 1'b0;
      else       feed_vld_ff <= feed_en;
      feed_tap_ff <= feed_tap;
   end

   logic [15:0] line_rd;

   c3br_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
      .clock (clock),
      .we    (req_fire && is_sample),
      .waddr (line_waddr),
      .wdata (req_bus.value),
      .raddr (line_raddr),
      .rdata (line_rd)
   );

   // wait for the last cell to take its final product
   always_ff @(posedge clock) begin
      if (reset) begin
         dr_ff <= '0;
      end else if (feed_en && feed_done) begin
         dr_ff <= DW'(DRAIN_CYC - 1);
      end else if (state_ff == ST_DRAIN && dr_ff != '0) begin
         dr_ff <= dr_ff - DW'(1);
      end
   end

   // ---------------- cell chain ----------------
   logic                                    bad_tap;
   logic [TW-1:0]                           wt_addr;
   cell_ctrl_type                           ctrl;
   logic                                    vld_chain [0:OUT_CHANNELS];
   logic signed [15:0]                      x_chain   [0:OUT_CHANNELS];
   logic [TW-1:0]                           tap_chain [0:OUT_CHANNELS];
   acc_type                                 acc_chain [0:OUT_CHANNELS];

   assign bad_tap = (req_bus.tap_row == 2'd3) || (req_bus.tap_col == 2'd3)
                 || (int'(req_bus.filter_index) >= OUT_CHANNELS)
                 || (int'(req_bus.channel_index) >= IN_CHANNELS);
   assign wt_addr = TW'((int'(req_bus.tap_row) * 3 + int'(req_bus.tap_col)) * IN_CHANNELS
                        + int'(req_bus.channel_index));

   always_comb begin
      ctrl.clear   = req_fire && is_sample && pix_fire;
      ctrl.shift   = unload_en;
      ctrl.wt_we   = req_fire && (req_bus.op == OP_WEIGHT) && !bad_tap;
      ctrl.bias_we = req_fire && (req_bus.op == OP_BIAS)
                  && (int'(req_bus.filter_index) < OUT_CHANNELS);
      ctrl.filter  = {1'b0, req_bus.filter_index};
   end

   assign vld_chain[0]            = feed_vld_ff;
   assign x_chain[0]              = $signed(line_rd);
   assign tap_chain[0]            = feed_tap_ff;
   assign acc_chain[OUT_CHANNELS] = '0;

   for (genvar j = 0; j < OUT_CHANNELS; j++) begin : g_cell
      c3br_cell #(.CELL_ID(j), .TAP_DEPTH(TAP_DEPTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wt_addr  (wt_addr),
         .wr_value (req_bus.value),
         .in_vld   (vld_chain[j]),
         .in_x     (x_chain[j]),
         .in_tap   (tap_chain[j]),
         .out_vld  (vld_chain[j+1]),
         .out_x    (x_chain[j+1]),
         .out_tap  (tap_chain[j+1]),
         .nbr_acc  (acc_chain[j+1]),
         .acc      (acc_chain[j])
      );
   end

   // ---------------- unload: scale, ReLU, saturate ----------------
   logic [4:0]  fi_ff;
   logic [QW-1:0] q;
   logic [14:0] act;

   assign fi_last = ({1'b0, fi_ff} + 6'd1) == eff_k;
   assign q       = QW'(acc_chain[0] >>> FRAC_W);
   always_comb begin
      if (acc_chain[0] <= 0)               act = 15'd0;
      else if (q > QW'(32767))             act = 15'h7FFF;
      else                                 act = q[14:0];
   end

   logic [4:0]  rsp_row_ff, rsp_col_ff, rsp_ch_ff;
   logic [14:0] rsp_act_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         fi_ff      <= '0;
      end else begin
         if (unload_en) begin
            rsp_vld_ff <= 1'b1;
            fi_ff      <= fi_last ? 5'd0 : fi_ff + 5'd1;
         end else if (rsp_bus.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (unload_en) begin
         rsp_row_ff  <= orow_ff;
         rsp_col_ff  <= ocol_ff;
         rsp_ch_ff   <= fi_ff;
         rsp_act_ff  <= act;
         rsp_last_ff <= fi_last;
      end
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.out_row     = rsp_row_ff;
   assign rsp_bus.out_col     = rsp_col_ff;
   assign rsp_bus.out_channel = rsp_ch_ff;
   assign rsp_bus.activation  = rsp_act_ff;
   assign rsp_bus.last        = rsp_last_ff;
endmodule

`default_nettype wire

[sv/c3br_checker.sv]
// Port-level checks of the convolution block and their bind to the top level.
// Depends on assert_macros.svh.
`default_nettype none

module c3br_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [4:0] rsp_out_row,
   input wire logic [4:0] rsp_out_col,
   input wire logic [4:0] rsp_out_channel,
   input wire logic [14:0] rsp_activation,
   input wire logic       rsp_last
);
   `include "assert_macros.svh"

   // a stalled word holds
   `C3BR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_out_channel) && $stable(rsp_activation) && $stable(rsp_last))
   // nothing pending right after reset
   `C3BR_ASSERT_NXT_ALL(a_rst_quiet, clock, reset, !rsp_valid)
   // no new request while a pixel is still unloading
   `C3BR_ASSERT_IMP(a_busy, clock, reset, rsp_valid && !rsp_last, !req_ready)
   // filters of a pixel follow without gaps
   `C3BR_ASSERT_NXT(a_no_gap, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   // filter index advances by one
   `C3BR_ASSERT_NXT(a_chan_step, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_out_channel == 5'($past(rsp_out_channel) + 5'd1))
endmodule

bind conv3x3_bias_relu c3br_checker u_c3br_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_row     (rsp_bus.out_row),
   .rsp_out_col     (rsp_bus.out_col),
   .rsp_out_channel (rsp_bus.out_channel),
   .rsp_activation  (rsp_bus.activation),
   .rsp_last        (rsp_bus.last)
);

`default_nettype wire

[dv/tb_top.sv]
// Testbench of the 3x3 convolution block with bias and ReLU: scoreboard check of every
// activation word against an in-bench predictor. Depends on c3br_pkg and c3br_ifs.
`default_nettype none

module tb_top;
   import c3br_pkg::*;

   localparam int MAXW  = 32;
   localparam int NCH   = 32;
   localparam int NFILT = 32;
   localparam int HOLD_OFF = 600;   // longest pixel: feed, drain and unload
   localparam int LOAD_FILT = 4;    // filters whose weights and bias get loaded
   localparam int LOAD_CH   = 2;    // input channels loaded for those filters

   typedef struct packed {
      logic [4:0]  row;
      logic [4:0]  col;
      logic [4:0]  chan;
      logic [14:0] act;
      logic        last;
   } act_word_type;

   logic clock;
   logic reset;

   c3br_req_if req_bus ();
   c3br_rsp_if rsp_bus ();
   c3br_csr_if csr_bus ();

   conv3x3_bias_relu DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor state: shadow stores, counters and registers.
   logic signed [15:0] line_mem [3*MAXW*NCH];
   logic signed [15:0] kern_mem [NFILT*9*NCH];
   logic signed [15:0] bias_mem [NFILT];
   int unsigned        row_cnt, col_cnt, chan_cnt;
   logic [5:0]         reg_width, reg_height, reg_in_chans, reg_out_chans;

   act_word_type expected_acts[$];
   int           error_count;
   bit           idle_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #6000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned eff_width();
      return clip(reg_width, 3, MAXW);
   endfunction
   function automatic int unsigned eff_height();
      return clip(reg_height, 3, 32);
   endfunction
   function automatic int unsigned eff_in();
      return clip(reg_in_chans, 1, NCH);
   endfunction
   function automatic int unsigned eff_out();
      return clip(reg_out_chans, 1, NFILT);
   endfunction

   // Apply one accepted request word to the shadow state and queue its activations.
   task automatic predict_conv(op_type op, logic [4:0] f, logic [1:0] tr, logic [1:0] tc,
                               logic [4:0] ch, logic signed [15:0] val);
      int unsigned  w, h, c, k;
      longint       acc, act;
      act_word_type aw;
      if (op == OP_WEIGHT) begin
         if (tr < 3 && tc < 3) kern_mem[((f*3 + tr)*3 + tc)*NCH + ch] = val;
         return;
      end
      if (op == OP_BIAS) begin
         bias_mem[f] = val;
         return;
      end
      if (op != OP_SAMPLE) return;
      w = eff_width();
      h = eff_height();
      c = eff_in();
      k = eff_out();
      // out-of-range counters after a register change start a fresh frame
      if (row_cnt >= h || col_cnt >= w || chan_cnt >= c) begin
         row_cnt = 0;
         col_cnt = 0;
         chan_cnt = 0;
      end
      line_mem[((row_cnt % 3)*MAXW + col_cnt)*NCH + chan_cnt] = val;
      if (chan_cnt + 1 == c && row_cnt >= 2 && col_cnt >= 2) begin
         for (int fi = 0; fi < k; fi++) begin
            acc = longint'(bias_mem[fi]) * 4096;
            for (int ki = 0; ki < 3; ki++)
               for (int li = 0; li < 3; li++)
                  for (int m = 0; m < c; m++)
                     acc += longint'(line_mem[(((row_cnt - 2 + ki) % 3)*MAXW
                                              + col_cnt - 2 + li)*NCH + m])
                          * longint'(kern_mem[((fi*3 + ki)*3 + li)*NCH + m]);
            if (acc <= 0) act = 0;
            else begin
               act = acc / 4096;
               if (act > 32767) act = 32767;
            end
            aw.row  = 5'(row_cnt - 2);
            aw.col  = 5'(col_cnt - 2);
            aw.chan = 5'(fi);
            aw.act  = 15'(act);
            aw.last = (fi + 1 == k);
            expected_acts.push_back(aw);
         end
      end
      chan_cnt++;
      if (chan_cnt >= c) begin
         chan_cnt = 0;
         col_cnt++;
         if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
         end
      end
   endtask

   // Send one request word; hold valid until the handshake, then predict.
   task automatic send_word(op_type op, logic [4:0] f, logic [1:0] tr, logic [1:0] tc,
                            logic [4:0] ch, logic signed [15:0] val);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.op            <= op;
      req_bus.filter_index  <= f;
      req_bus.tap_row       <= tr;
      req_bus.tap_col       <= tc;
      req_bus.channel_index <= ch;
      req_bus.value         <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_conv(op, f, tr, tc, ch, val);
   endtask

   task automatic send_sample(logic signed [15:0] val);
      send_word(OP_SAMPLE, 5'($urandom), 2'($urandom), 2'($urandom), 5'($urandom), val);
   endtask

   function automatic logic signed [15:0] rand_value();
      // half full range, half small so sums do not always clip
      if ($urandom_range(0, 1)) return 16'($urandom);
      return 16'($signed($urandom_range(0, 4095)) - 2048);
   endfunction

   // Wait for the block to drain, then let any tail work finish.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_acts.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // Hold valid high across back-to-back writes; the caller drops it.
   task automatic write_reg(logic [1:0] idx, logic [5:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_MAP_WIDTH:  reg_width     = data;
         CSR_MAP_HEIGHT: reg_height    = data;
         CSR_IN_CHANS:   reg_in_chans  = data;
         default:        reg_out_chans = data;
      endcase
   endtask

   task automatic set_map(logic [5:0] w, logic [5:0] h, logic [5:0] c, logic [5:0] k);
      wait_idle();
      write_reg(CSR_MAP_WIDTH, w);
      write_reg(CSR_MAP_HEIGHT, h);
      write_reg(CSR_IN_CHANS, c);
      write_reg(CSR_OUT_CHANS, k);
      csr_bus.valid <= 1'b0;
   endtask

   // Stream one whole frame so the counters end back at the origin.
   task automatic send_frame();
      int unsigned n;
      n = eff_width() * eff_height() * eff_in();
      for (int i = 0; i < n; i++) send_sample(rand_value());
   endtask

   // Fill every store entry any later frame can read.
   task automatic test_load_stores();
      for (int f = 0; f < LOAD_FILT; f++) begin
         send_word(OP_BIAS, 5'(f), 2'd0, 2'd0, 5'd0, rand_value());
         for (int t = 0; t < 9; t++)
            for (int ch = 0; ch < LOAD_CH; ch++)
               send_word(OP_WEIGHT, 5'(f), 2'(t / 3), 2'(t % 3), 5'(ch), rand_value());
      end
   endtask

   // Extreme values through the smallest map, every loaded filter.
   task automatic test_edge_values();
      set_map(6'd3, 6'd3, 6'd1, 6'(LOAD_FILT));
      send_word(OP_WEIGHT, 5'd3, 2'd2, 2'd2, 5'd0, 16'sh7FFF);
      send_word(OP_WEIGHT, 5'd2, 2'd0, 2'd0, 5'd0, -16'sh8000);
      send_word(OP_BIAS, 5'd3, 2'd0, 2'd0, 5'd0, 16'sh7FFF);
      send_word(OP_BIAS, 5'd2, 2'd0, 2'd0, 5'd0, -16'sh8000);
      for (int i = 0; i < 9; i++) send_sample(i[0] ? 16'sh7FFF : -16'sh8000);
      for (int i = 0; i < 9; i++) send_sample(16'sh0000);
   endtask

   // Unused op and bad tap addresses must leave the stores alone.
   task automatic test_ignored_words();
      send_word(OP_NONE, 5'd0, 2'd0, 2'd0, 5'd0, 16'sh7FFF);
      send_word(OP_WEIGHT, 5'd0, 2'd3, 2'd0, 5'd0, 16'sh1234);
      send_word(OP_WEIGHT, 5'd1, 2'd0, 2'd3, 5'd1, -16'sh1234);
      send_word(OP_WEIGHT, 5'd2, 2'd3, 2'd3, 5'd31, 16'sh4000);
      send_frame();
   endtask

   // Shrink width or channels while counters sit past the new limit.
   task automatic test_frame_restart();
      set_map(6'd5, 6'd4, 6'd1, 6'd3);
      for (int i = 0; i < 14; i++) send_sample(rand_value());
      set_map(6'd3, 6'd4, 6'd1, 6'd3);
      send_frame();
      set_map(6'd4, 6'd3, 6'd2, 6'd2);
      for (int i = 0; i < 13; i++) send_sample(rand_value());
      set_map(6'd4, 6'd3, 6'd1, 6'd2);
      send_frame();
   endtask

   // Registers at and beyond their limits.
   task automatic test_register_extremes();
      set_map(6'd63, 6'd0, 6'd0, 6'd0);
      send_frame();
   endtask

   // Random small maps, store rewrites and noise words.
   task automatic test_random_frames();
      int unsigned sent;
      sent = 0;
      while (sent < 100) begin
         set_map(6'($urandom_range(3, 5)), 6'($urandom_range(3, 4)),
                 6'($urandom_range(1, LOAD_CH)), 6'($urandom_range(1, LOAD_FILT)));
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
               0: send_word(OP_BIAS, 5'($urandom), 2'd0, 2'd0, 5'd0, rand_value());
               1: send_word(OP_NONE, 5'($urandom), 2'($urandom), 2'($urandom),
                            5'($urandom), 16'($urandom));
               default: send_word(OP_WEIGHT, 5'($urandom), 2'($urandom), 2'($urandom),
                                  5'($urandom), rand_value());
            endcase
            sent++;
         end
         sent += eff_width() * eff_height() * eff_in();
         send_frame();
      end
   endtask

   // Back-to-back words and an always-ready sink.
   task automatic test_streaming_no_idle();
      set_map(6'd4, 6'd3, 6'd2, 6'(LOAD_FILT));
      idle_on = 1'b0;
      send_frame();
   endtask

   // Sink side: random stall bursts, check each activation word.
   int unsigned stall_left;
   always @(posedge clock) begin
      act_word_type exp_w;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_acts.size() == 0) begin
               $error("unexpected activation word row=%0d col=%0d chan=%0d",
                      rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_channel);
               error_count++;
            end else begin
               exp_w = expected_acts.pop_front();
               if (rsp_bus.out_row !== exp_w.row) begin
                  $error("out_row exp %0d got %0d", exp_w.row, rsp_bus.out_row);
                  error_count++;
               end
               if (rsp_bus.out_col !== exp_w.col) begin
                  $error("out_col exp %0d got %0d", exp_w.col, rsp_bus.out_col);
                  error_count++;
               end
               if (rsp_bus.out_channel !== exp_w.chan) begin
                  $error("out_channel exp %0d got %0d", exp_w.chan, rsp_bus.out_channel);
                  error_count++;
               end
               if (rsp_bus.activation !== exp_w.act) begin
                  $error("activation exp %0d got %0d", exp_w.act, rsp_bus.activation);
                  error_count++;
               end
               if (rsp_bus.last !== exp_w.last) begin
                  $error("last exp %0d got %0d", exp_w.last, rsp_bus.last);
                  error_count++;
               end
            end
         end
         // hold ready low for a burst now and then
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.op            = OP_NONE;
      req_bus.filter_index  = '0;
      req_bus.tap_row       = '0;
      req_bus.tap_col       = '0;
      req_bus.channel_index = '0;
      req_bus.value         = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_MAP_WIDTH;
      csr_bus.data          = '0;
      row_cnt               = 0;
      col_cnt               = 0;
      chan_cnt              = 0;
      reg_width             = 6'd30;
      reg_height            = 6'd30;
      reg_in_chans          = 6'd1;
      reg_out_chans         = 6'd32;
      error_count           = 0;
      idle_on               = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_load_stores();
      test_edge_values();
      test_ignored_words();
      test_frame_restart();
      test_register_extremes();
      test_random_frames();
      test_streaming_no_idle();

      // drain and let the tail settle
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_acts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
